>>> rtl/hepm_pkg.sv
// hepm_pkg: command and edge kind codes, store depth and defaults for the
// hall edge period meter; no dependencies
package hepm_pkg;

    localparam int DEPTH            = 5;
    localparam int COUNT_W          = $clog2(DEPTH + 1);
    localparam int TIME_WIDTH_DEF   = 32;
    localparam int FRAC_BITS        = 12;
    localparam int RATE_W           = 16;
    localparam int CMD_W            = 2;
    localparam int STAMP_W          = 32;
    localparam logic [RATE_W-1:0] NOISE_RATE_RESET = 16'd2048;

    typedef enum logic [CMD_W-1:0] {
        CMD_RISE    = 2'd0,
        CMD_FALL    = 2'd1,
        CMD_TIMEOUT = 2'd2,
        CMD_QUERY   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_RISE = 2'd1,
        KIND_FALL = 2'd2
    } kind_t;

endpackage

>>> rtl/hall_edge_period_meter_core.sv
// hall_edge_period_meter_core: top level of the hall edge period meter
// uses hepm_pkg for codes and constants
//
// One item per clock cycle is taken. Each word lands in an input register;
// from there the edge store, period and last edge time are updated
// in a single pass and the result word is written to the output register,
// so a result passes the input register and then the output register. The
// sustained rate is set by that state update (spike threshold multiply
// and compare, store shift and span average). Input stalls only while a
// finished result waits in the output register. The noise_rate register
// write port is always ready. No clearing pass after reset.
module hall_edge_period_meter_core
    import hepm_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CMD_W-1:0]   cmd,
    input  logic [STAMP_W-1:0] timestamp,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [STAMP_W-1:0] period,
    output logic [STAMP_W-1:0] reported_period,
    output logic               spike_dropped,
    output logic               edge_ignored,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [RATE_W-1:0]  noise_rate
);

    localparam int PROD_W = TIME_WIDTH + RATE_W;

    logic                  in_valid_reg;
    cmd_t                  cmd_reg;
    logic [TIME_WIDTH-1:0] time_reg;

    logic [TIME_WIDTH-1:0] edge_times_reg [DEPTH];
    logic [TIME_WIDTH-1:0] edge_times_next [DEPTH];
    logic [COUNT_W-1:0]    held_count_reg, held_count_next;
    logic [TIME_WIDTH-1:0] avg_period_reg, avg_period_next;
    logic [TIME_WIDTH-1:0] last_time_reg, last_time_next;
    kind_t                 last_kind_reg, last_kind_next;
    logic [RATE_W-1:0]     noise_rate_reg;

    logic                  out_valid_reg;
    logic [STAMP_W-1:0]    period_reg, period_next;
    logic [STAMP_W-1:0]    reported_reg, reported_next;
    logic                  spike_reg, spike_next;
    logic                  ignored_reg, ignored_next;

    logic                  advance;
    logic                  in_take;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign in_take   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        logic                  is_edge;
        kind_t                 kind;
        logic                  accept;
        logic                  full;
        logic [TIME_WIDTH-1:0] next_iv;
        logic [TIME_WIDTH-1:0] last_iv;
        logic [TIME_WIDTH-1:0] max_iv;
        logic [PROD_W-1:0]     prod;
        logic [PROD_W-1:0]     scaled_iv;
        logic                  below;
        logic [TIME_WIDTH-1:0] span_a;
        logic [TIME_WIDTH-1:0] span_b;
        logic [TIME_WIDTH-1:0] since;
        logic [TIME_WIDTH-1:0] rep;

        is_edge = 1'b0;
        kind    = KIND_NONE;
        unique case (cmd_reg) inside
            CMD_RISE:
            begin
                is_edge = 1'b1;
                kind    = KIND_RISE;
            end
            CMD_FALL:
            begin
                is_edge = 1'b1;
                kind    = KIND_FALL;
            end
            CMD_TIMEOUT, CMD_QUERY:
            begin
                is_edge = 1'b0;
                kind    = KIND_NONE;
            end
            default:
            begin
                is_edge = 1'b0;
                kind    = KIND_NONE;
            end
        endcase

        ignored_next = is_edge && (kind == last_kind_reg);
        accept       = is_edge && !ignored_next;
        full         = (held_count_reg == COUNT_W'(DEPTH));

        next_iv   = time_reg - edge_times_reg[DEPTH-1];
        last_iv   = edge_times_reg[DEPTH-1] - edge_times_reg[DEPTH-2];
        max_iv    = (next_iv > last_iv) ? next_iv : last_iv;
        prod      = PROD_W'(avg_period_reg) * PROD_W'(noise_rate_reg);
        scaled_iv = PROD_W'({max_iv, {FRAC_BITS{1'b0}}});
        below     = (scaled_iv < prod);

        spike_next = accept && full && below;

        edge_times_next = edge_times_reg;
        held_count_next = held_count_reg;
        avg_period_next = avg_period_reg;
        last_time_next  = last_time_reg;
        last_kind_next  = last_kind_reg;

        if (cmd_reg == CMD_TIMEOUT)
        begin
            held_count_next = '0;
            avg_period_next = '0;
            last_time_next  = '0;
        end
        else if (accept)
        begin
            last_kind_next = kind;
            last_time_next = time_reg;
            if (spike_next)
            begin
                held_count_next = COUNT_W'(DEPTH - 1);
            end
            else if (full)
            begin
                for (int i = 0; i < DEPTH - 1; i++)
                begin
                    edge_times_next[i] = edge_times_reg[i+1];
                end
                edge_times_next[DEPTH-1] = time_reg;
            end
            else
            begin
                edge_times_next[held_count_reg] = time_reg;
                held_count_next = held_count_reg + COUNT_W'(1);
            end
        end

        span_a = edge_times_next[3] - edge_times_next[1];
        span_b = edge_times_next[2] - edge_times_next[0];
        if (accept && !spike_next && (held_count_next == COUNT_W'(DEPTH)))
        begin
            avg_period_next = (span_a >> 1) + (span_b >> 1)
                            + TIME_WIDTH'(span_a[0] & span_b[0]);
        end

        since = time_reg - last_time_next;
        rep   = '0;
        if (avg_period_next != '0)
        begin
            rep = (avg_period_next > since) ? avg_period_next : since;
        end

        period_next   = STAMP_W'(avg_period_next);
        reported_next = STAMP_W'(rep);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            held_count_reg <= '0;
            avg_period_reg <= '0;
            last_time_reg  <= '0;
            last_kind_reg  <= KIND_NONE;
            noise_rate_reg <= NOISE_RATE_RESET;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                noise_rate_reg <= noise_rate;
            end
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                held_count_reg <= held_count_next;
                avg_period_reg <= avg_period_next;
                last_time_reg  <= last_time_next;
                last_kind_reg  <= last_kind_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg  <= cmd_t'(cmd);
            time_reg <= TIME_WIDTH'(timestamp);
        end
        if (advance)
        begin
            edge_times_reg <= edge_times_next;
            period_reg     <= period_next;
            reported_reg   <= reported_next;
            spike_reg      <= spike_next;
            ignored_reg    <= ignored_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign period          = period_reg;
    assign reported_period = reported_reg;
    assign spike_dropped   = spike_reg;
    assign edge_ignored    = ignored_reg;

endmodule

>>> rtl/hepm_checker.sv
// hepm_checker: port-level assertions for hall_edge_period_meter_core
// uses hepm_pkg; bound to the top level at the end of this file
module hepm_checker
    import hepm_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [CMD_W-1:0]   cmd,
    input logic [STAMP_W-1:0] timestamp,
    input logic               out_valid,
    input logic               out_ready,
    input logic [STAMP_W-1:0] period,
    input logic [STAMP_W-1:0] reported_period,
    input logic               spike_dropped,
    input logic               edge_ignored
);

    localparam bit NARROW = (TIME_WIDTH <= STAMP_W);

    // waiting input word holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(cmd) && $stable(timestamp))
        else $error("waiting input word changed");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(period)
            && $stable(reported_period) && $stable(spike_dropped)
            && $stable(edge_ignored))
        else $error("stalled result word changed");

    // input backs up only behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty output");

    // an edge is either ignored or a spike, never both
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(spike_dropped && edge_ignored))
        else $error("spike and ignore flags both set");

    // reported period follows the period
    a_report: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !NARROW
            || ((period == '0) && (reported_period == '0))
            || ((period != '0) && (reported_period >= period)))
        else $error("reported period inconsistent with period");

endmodule

bind hall_edge_period_meter_core hepm_checker #(.TIME_WIDTH(TIME_WIDTH)) u_hepm_checker (.*);

>>> sim/testbench.sv
// testbench for hall_edge_period_meter_core: edge, timeout and query words
// checked against a period and spike model kept in this file
// depends on rtl/hepm_pkg.sv and rtl/hall_edge_period_meter_core.sv
module testbench;
    import hepm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STAMP_W-1:0] period;
        logic [STAMP_W-1:0] reported;
        logic               spike;
        logic               ignored;
    } meter_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [CMD_W-1:0]   cmd;
    logic [STAMP_W-1:0] timestamp;
    logic               out_valid;
    logic               out_ready;
    logic [STAMP_W-1:0] period;
    logic [STAMP_W-1:0] reported_period;
    logic               spike_dropped;
    logic               edge_ignored;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [RATE_W-1:0]  noise_rate;

    meter_result_t      pending_results[$];
    logic [STAMP_W-1:0] held_times[DEPTH];
    int unsigned        held_total;
    logic [STAMP_W-1:0] mean_period;
    logic [STAMP_W-1:0] last_time;
    kind_t              last_kind;
    logic [RATE_W-1:0]  spike_rate;

    int unsigned        send_idle_pct;
    int unsigned        recv_idle_pct;
    int unsigned        mismatches;

    hall_edge_period_meter_core DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .cmd             (cmd),
        .timestamp       (timestamp),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .period          (period),
        .reported_period (reported_period),
        .spike_dropped   (spike_dropped),
        .edge_ignored    (edge_ignored),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .noise_rate      (noise_rate)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic compute_meter_result(input cmd_t c, input logic [STAMP_W-1:0] ts);
        meter_result_t      r;
        kind_t              k;
        logic [STAMP_W-1:0] new_iv;
        logic [STAMP_W-1:0] old_iv;
        logic [STAMP_W-1:0] widest;
        logic [STAMP_W-1:0] span_a;
        logic [STAMP_W-1:0] span_b;
        logic [STAMP_W-1:0] since;
        r = '0;
        if (c == CMD_RISE || c == CMD_FALL)
        begin
            k = (c == CMD_RISE) ? KIND_RISE : KIND_FALL;
            if (k == last_kind)
                r.ignored = 1'b1;
            else
            begin
                if (held_total == DEPTH)
                begin
                    new_iv = ts - held_times[4];
                    old_iv = held_times[4] - held_times[3];
                    widest = (new_iv > old_iv) ? new_iv : old_iv;
                    if ((64'(widest) << FRAC_BITS) < 64'(mean_period) * 64'(spike_rate))
                    begin
                        held_total    = DEPTH - 1;
                        held_times[4] = '0;
                        r.spike       = 1'b1;
                    end
                    else
                    begin
                        for (int i = 0; i < DEPTH - 1; i++)
                            held_times[i] = held_times[i+1];
                        held_times[DEPTH-1] = ts;
                    end
                end
                else
                begin
                    held_times[held_total] = ts;
                    held_total++;
                end
                if (!r.spike && held_total == DEPTH)
                begin
                    span_a      = held_times[3] - held_times[1];
                    span_b      = held_times[2] - held_times[0];
                    mean_period = (span_a >> 1) + (span_b >> 1) + (span_a & span_b & 1);
                end
                last_kind = k;
                last_time = ts;
            end
        end
        else if (c == CMD_TIMEOUT)
        begin
            for (int i = 0; i < DEPTH; i++)
                held_times[i] = '0;
            held_total  = 0;
            mean_period = '0;
            last_time   = '0;
        end
        r.period = mean_period;
        if (mean_period != 0)
        begin
            since      = ts - last_time;
            r.reported = (mean_period > since) ? mean_period : since;
        end
        pending_results = {pending_results, r};
    endtask

    task automatic send_word(input cmd_t c, input logic [STAMP_W-1:0] ts);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= c;
        timestamp <= ts;
        do @(posedge clk); while (!in_ready);
        compute_meter_result(c, ts);
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_noise_rate(input logic [RATE_W-1:0] value);
        wait_results_drained();
        cfg_valid  <= 1'b1;
        noise_rate <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        spike_rate = value;
    endtask

    task automatic check_field(input string name, input logic [STAMP_W-1:0] want,
                               input logic [STAMP_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        meter_result_t want;
        if (rst_n)
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected word expected none actual %0h %0h %0b %0b", $time,
                         period, reported_period, spike_dropped, edge_ignored);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("period", want.period, period);
                check_field("reported_period", want.reported, reported_period);
                check_field("spike_dropped", STAMP_W'(want.spike), STAMP_W'(spike_dropped));
                check_field("edge_ignored", STAMP_W'(want.ignored), STAMP_W'(edge_ignored));
            end
        end
    end

    task automatic test_startup_state();
        send_word(CMD_QUERY, 32'hFFFF_FFFF);
        send_word(CMD_TIMEOUT, 32'h0000_0000);
        send_word(CMD_QUERY, 32'h0000_0000);
    endtask

    task automatic test_wrapping_edges();
        logic [STAMP_W-1:0] t;
        t = 32'hFFFF_FF00;
        send_word(CMD_FALL, t);
        send_word(CMD_RISE, t + 60);
        send_word(CMD_FALL, t + 120);
        send_word(CMD_RISE, t + 180);
        send_word(CMD_FALL, t + 240);
        send_word(CMD_FALL, t + 250);
        send_word(CMD_RISE, t + 300);
        send_word(CMD_QUERY, t + 1000);
        send_word(CMD_QUERY, t + 100);
    endtask

    task automatic test_spike_drop();
        logic [STAMP_W-1:0] t;
        t = 32'h0000_002C;
        send_word(CMD_FALL, t + 5);
        send_word(CMD_RISE, t + 10);
        send_word(CMD_FALL, t + 60);
        send_word(CMD_RISE, t + 120);
    endtask

    task automatic test_timeout_keeps_kind();
        send_word(CMD_TIMEOUT, 32'h1234_5678);
        send_word(CMD_QUERY, 32'h1234_5680);
        send_word(CMD_RISE, 32'h1234_5690);
        send_word(CMD_FALL, 32'h0000_0000);
        send_word(CMD_RISE, 32'hFFFF_FFFF);
        send_word(CMD_QUERY, 32'h8000_0000);
    endtask

    function automatic cmd_t next_edge_cmd();
        return (last_kind == KIND_RISE) ? CMD_FALL : CMD_RISE;
    endfunction

    function automatic logic [STAMP_W-1:0] pick_half_period();
        if ($urandom_range(9) == 0)
            return $urandom_range(32'h0010_0000, 32'h4000_0000);
        return $urandom_range(2, 2000);
    endfunction

    task automatic test_random_traffic(input int n_items);
        logic [STAMP_W-1:0] now;
        logic [STAMP_W-1:0] half;
        logic [STAMP_W-1:0] glitch;
        int                 pick;
        int                 sent;
        now  = $urandom;
        half = pick_half_period();
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 64)
            begin
                now = now + half - (half >> 3) + $urandom_range(0, half >> 2);
                send_word(next_edge_cmd(), now);
                sent++;
            end
            else if (pick < 74)
            begin
                glitch = $urandom_range(1, (half >> 2) + 1);
                now = now + glitch;
                send_word(next_edge_cmd(), now);
                now = now + glitch;
                send_word(next_edge_cmd(), now);
                now = now + half;
                sent += 2;
            end
            else if (pick < 82)
            begin
                send_word(CMD_QUERY, now + $urandom_range(0, half << 2));
                sent++;
            end
            else if (pick < 87)
            begin
                send_word((last_kind == KIND_FALL) ? CMD_FALL : CMD_RISE,
                          now + $urandom_range(0, half));
                sent++;
            end
            else if (pick < 90)
            begin
                send_word(CMD_TIMEOUT, $urandom);
                now  = $urandom;
                half = pick_half_period();
                sent++;
            end
            else if (pick < 95)
            begin
                send_word(cmd_t'($urandom_range(3)), $urandom);
                sent++;
            end
            else
                half = pick_half_period();
        end
    endtask

    initial
    begin
        logic [RATE_W-1:0] rate_plan[6];
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        cmd           <= CMD_QUERY;
        timestamp     <= '0;
        out_ready     <= 1'b0;
        cfg_valid     <= 1'b0;
        noise_rate    <= NOISE_RATE_RESET;
        send_idle_pct = 26;
        recv_idle_pct = 53;
        mismatches    = 0;
        for (int i = 0; i < DEPTH; i++)
            held_times[i] = '0;
        held_total  = 0;
        mean_period = '0;
        last_time   = '0;
        last_kind   = KIND_NONE;
        spike_rate  = NOISE_RATE_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_startup_state();
        test_wrapping_edges();
        test_spike_drop();
        test_timeout_keeps_kind();

        rate_plan = '{16'hFFFF, 16'h0000, 16'd2048, RATE_W'($urandom), 16'h0001,
                      RATE_W'($urandom_range(1024, 8192))};
        for (int seg = 0; seg < 6; seg++)
        begin
            case (seg / 2)
                0:
                begin
                    send_idle_pct = 26;
                    recv_idle_pct = 53;
                end
                1:
                begin
                    send_idle_pct = 53;
                    recv_idle_pct = 26;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_noise_rate(rate_plan[seg]);
            test_random_traffic(64);
        end

        wait_results_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
